// ===== rtl/core/rsj_pkg.sv =====
`default_nettype none
package rsj_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SUMMING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SUMMING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SAMPLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LINE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_COUNT     = 3'd5;

    localparam logic [2:0] MODE_LOAD_TIME  = 3'd0;
    localparam logic [2:0] MODE_LOAD_SCOEF = 3'd1;
    localparam logic [2:0] MODE_LOAD_LCOEF = 3'd2;
    localparam logic [2:0] MODE_P2D        = 3'd3;
    localparam logic [2:0] MODE_D2P        = 3'd4;

    localparam int         DIV_STEPS  = 50;
    localparam int         MAX_ROUNDS = 50;
    localparam logic [5:0] DIV_LAST   = 6'(DIV_STEPS - 1);
    localparam logic [5:0] ROUND_LAST = 6'(MAX_ROUNDS);

    localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] S48_MIN = -64'sh0000_8000_0000_0000;
    localparam logic signed [63:0] ONE_Q24 = 64'sh0000_0000_0100_0000;

    typedef struct packed {
        logic [2:0]         mode;
        logic [11:0]        entry_index;
        logic signed [47:0] entry_value;
        logic signed [47:0] sample_in;
        logic signed [47:0] line_in;
    } t_item;

    typedef struct packed {
        logic signed [47:0] parent_sample;
        logic signed [47:0] parent_line;
        logic signed [47:0] detector_sample;
        logic signed [47:0] detector_line;
        logic               status;
    } t_result;

    typedef struct packed {
        logic wr_time;
        logic wr_scoef;
        logic wr_lcoef;
        logic load_in;
        logic div_init;
        logic div_step;
        logic div_fin;
        logic t_load;
        logic h_add;
        logic h_mulh;
        logic h_mull;
        logic h_comb;
        logic jit;
        logic scale;
        logic update;
        logic set_status;
        logic status_val;
    } t_cmd;

    typedef struct packed {
        logic h_none;
        logic h_last;
        logic conv;
    } t_sts;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x;
        if (x > S48_MAX) begin
            y = S48_MAX;
        end else if (x < S48_MIN) begin
            y = S48_MIN;
        end
        return y[47:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rolling_shutter_jitter_map_unit.sv =====
// Load transactions (modes 0-2) stay in idle; unused modes are dropped at once.
// Parent to detector: row lookup, time load, a Horner step per coefficient, jitter, scale.
// Detector to parent: the bit-serial divider, then R = 1..51 jitter evaluations, each a row
// lookup, time load, Horner steps of each lane, jitter and a convergence check.
// One transaction at a time; the result strobe is one cycle and cannot be stalled.
// Synchronous active-low reset: config registers to 1, status and Horner index to 0, controller idle.
`default_nettype none
module rolling_shutter_jitter_map_unit import rsj_pkg::*; #(
    parameter int MAX_LINES  = 4096,
    parameter int MAX_COEFFS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_valid,
    output t_result                    o_result
);

    t_cmd w_cmd;
    t_sts w_sts;

    rsj_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    rsj_dp #(
        .MAX_LINES  (MAX_LINES),
        .MAX_COEFFS (MAX_COEFFS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rsj_ram.sv =====
`default_nettype none
module rsj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/rsj_ctrl.sv =====
`default_nettype none
module rsj_ctrl import rsj_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic [2:0] i_mode,
    input  wire t_sts  i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DIV   = 13'b0000000000010,
        S_DFIN  = 13'b0000000000100,
        S_ROW   = 13'b0000000001000,
        S_TLD   = 13'b0000000010000,
        S_HADD  = 13'b0000000100000,
        S_HMH   = 13'b0000001000000,
        S_HML   = 13'b0000010000000,
        S_HCMB  = 13'b0000100000000,
        S_JIT   = 13'b0001000000000,
        S_SCALE = 13'b0010000000000,
        S_CHK   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       r_p2d, n_p2d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_p2d   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_p2d   <= n_p2d;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_p2d   = r_p2d;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_mode)
                        MODE_LOAD_TIME:  o_cmd.wr_time  = 1'b1;
                        MODE_LOAD_SCOEF: o_cmd.wr_scoef = 1'b1;
                        MODE_LOAD_LCOEF: o_cmd.wr_lcoef = 1'b1;
                        MODE_P2D: begin
                            o_cmd.load_in = 1'b1;
                            n_p2d         = 1'b1;
                            n_state       = S_ROW;
                        end
                        MODE_D2P: begin
                            o_cmd.load_in  = 1'b1;
                            o_cmd.div_init = 1'b1;
                            n_p2d          = 1'b0;
                            n_cnt          = '0;
                            n_state        = S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.div_fin = 1'b1;
                n_cnt         = '0;
                n_state       = S_ROW;
            end
            S_ROW: n_state = S_TLD;
            S_TLD: begin
                o_cmd.t_load = 1'b1;
                n_state      = i_sts.h_none ? S_JIT : S_HADD;
            end
            S_HADD: begin
                o_cmd.h_add = 1'b1;
                n_state     = S_HMH;
            end
            S_HMH: begin
                o_cmd.h_mulh = 1'b1;
                n_state      = S_HML;
            end
            S_HML: begin
                o_cmd.h_mull = 1'b1;
                n_state      = S_HCMB;
            end
            S_HCMB: begin
                o_cmd.h_comb = 1'b1;
                n_state      = i_sts.h_last ? S_JIT : S_HADD;
            end
            S_JIT: begin
                o_cmd.jit = 1'b1;
                n_state   = r_p2d ? S_SCALE : S_CHK;
            end
            S_SCALE: begin
                o_cmd.scale      = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status_val = 1'b0;
                n_state          = S_OUT;
            end
            S_CHK: begin
                if (i_sts.conv) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = 1'b0;
                    n_state          = S_OUT;
                end else if (r_cnt == ROUND_LAST) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status_val = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.update = 1'b1;
                    n_cnt        = r_cnt + 6'd1;
                    n_state      = S_ROW;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule
`default_nettype wire

// ===== rtl/core/rsj_dp.sv =====
`default_nettype none
module rsj_dp import rsj_pkg::*; #(
    parameter int MAX_LINES  = 4096,
    parameter int MAX_COEFFS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_item                 i_item,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output t_result                    o_result
);

    localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int KW = $clog2(MAX_COEFFS + 1);

    // configuration
    logic [6:0]  r_cfg_sum   [2];
    logic [15:0] r_cfg_start [2];
    logic [3:0]  r_cfg_cc;
    logic [12:0] r_cfg_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sum[0]   <= 7'd1;
            r_cfg_sum[1]   <= 7'd1;
            r_cfg_start[0] <= 16'd1;
            r_cfg_start[1] <= 16'd1;
            r_cfg_cc       <= 4'd1;
            r_cfg_tc       <= 13'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_SUMMING: r_cfg_sum[0]   <= i_cfg_data[6:0];
                CFG_LINE_SUMMING:   r_cfg_sum[1]   <= i_cfg_data[6:0];
                CFG_START_SAMPLE:   r_cfg_start[0] <= i_cfg_data;
                CFG_START_LINE:     r_cfg_start[1] <= i_cfg_data;
                CFG_COEFF_COUNT:    r_cfg_cc       <= i_cfg_data[3:0];
                CFG_TIME_COUNT:     r_cfg_tc       <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // lane 0 is sample, lane 1 is line
    logic signed [47:0] r_p    [2];
    logic signed [47:0] r_d    [2];
    logic signed [47:0] r_tg   [2];
    logic signed [47:0] r_j    [2];
    logic signed [47:0] r_acc  [2];
    logic        [47:0] r_us   [2];
    logic               r_mneg [2];
    logic        [63:0] r_ph   [2];
    logic        [63:0] r_pq   [2];
    logic        [49:0] r_dn   [2];
    logic        [7:0]  r_dr   [2];
    logic               r_dneg [2];
    logic signed [47:0] r_coef [2][MAX_COEFFS];
    logic        [31:0] r_ut;
    logic               r_tneg;
    logic [KW-1:0]      r_k;
    logic               r_status;

    logic signed [47:0] w_in   [2];
    logic        [6:0]  w_sum  [2];
    logic signed [48:0] w_x    [2];
    logic        [48:0] w_u    [2];
    logic        [49:0] w_n    [2];
    logic        [8:0]  w_rs   [2];
    logic        [8:0]  w_dv   [2];
    logic               w_ge   [2];
    logic        [8:0]  w_rn   [2];
    logic signed [50:0] w_qs   [2];
    logic signed [47:0] w_tgn  [2];
    logic signed [47:0] w_hs   [2];
    logic        [47:0] w_hu   [2];
    logic        [31:0] w_ma   [2];
    logic        [63:0] w_prod [2];
    logic        [63:0] w_r    [2];
    logic        [63:0] w_q    [2];
    logic signed [47:0] w_hres [2];
    logic        [47:0] w_au   [2];
    logic        [48:0] w_jm   [2];
    logic signed [63:0] w_jit  [2];
    logic signed [47:0] w_js   [2];
    logic signed [63:0] w_df   [2];
    logic               w_ok   [2];
    logic signed [47:0] w_upd  [2];
    logic signed [48:0] w_pm   [2];
    logic signed [56:0] w_pmul [2];
    logic signed [47:0] w_sc   [2];

    logic [KW-1:0] w_neff;
    logic [31:0]   w_cc32;
    logic [31:0]   w_tc32;
    logic [31:0]   w_cnt;
    logic [48:0]   w_lr;
    logic [31:0]   w_row;
    logic [31:0]   w_ra32;
    logic [31:0]   w_wa32;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rdata;
    logic          w_twe;
    logic          w_cok;

    assign w_in[0]  = i_item.sample_in;
    assign w_in[1]  = i_item.line_in;
    assign w_cc32   = 32'(r_cfg_cc);
    assign w_tc32   = 32'(r_cfg_tc);
    assign w_neff   = (w_cc32 > 32'(MAX_COEFFS)) ? KW'(MAX_COEFFS) : KW'(w_cc32);
    assign w_wa32   = 32'(i_item.entry_index);
    assign w_twe    = i_cmd.wr_time && (w_wa32 < 32'(MAX_LINES));
    assign w_cok    = (w_wa32 < 32'(MAX_COEFFS));

    always_comb begin
        if (w_tc32 == 32'd0) begin
            w_cnt = 32'd1;
        end else if (w_tc32 > 32'(MAX_LINES)) begin
            w_cnt = 32'(MAX_LINES);
        end else begin
            w_cnt = w_tc32;
        end
        w_lr = 49'(r_p[1]) + 49'(24'h80_0000);
        w_row = r_p[1][47] ? 32'd0 : 32'(w_lr[48:24]);
        if (w_row < 32'd1) begin
            w_row = 32'd1;
        end
        if (w_row > w_cnt) begin
            w_row = w_cnt;
        end
        w_ra32  = w_row - 32'd1;
        w_raddr = w_ra32[AW-1:0];
    end

    rsj_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LINES)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_twe),
        .i_waddr (w_wa32[AW-1:0]),
        .i_wdata (i_item.entry_value[31:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_sum[i] = (r_cfg_sum[i] == 7'd0) ? 7'd1 : r_cfg_sum[i];
            // rounded division setup
            w_x[i]  = 49'(w_in[i]) - 49'({r_cfg_start[i], 24'b0});
            w_u[i]  = w_x[i][48] ? 49'(-w_x[i]) : 49'(w_x[i]);
            w_n[i]  = 50'({w_u[i][47:0], 1'b0}) + 50'(w_sum[i]);
            w_rs[i] = {r_dr[i], r_dn[i][49]};
            w_dv[i] = 9'({w_sum[i], 1'b0});
            w_ge[i] = (w_rs[i] >= w_dv[i]);
            w_rn[i] = w_ge[i] ? (w_rs[i] - w_dv[i]) : w_rs[i];
            w_qs[i] = r_dneg[i] ? -$signed({1'b0, r_dn[i]}) : $signed({1'b0, r_dn[i]});
            w_tgn[i] = sat48(64'(w_qs[i]) + ONE_Q24);
            // Horner step
            w_hs[i]   = sat48(64'(r_acc[i]) + 64'(r_coef[i][r_k[CW-1:0]]));
            w_hu[i]   = w_hs[i][47] ? 48'(-w_hs[i]) : 48'(w_hs[i]);
            w_ma[i]   = i_cmd.h_mulh ? r_us[i][47:16] : {16'b0, r_us[i][15:0]};
            w_prod[i] = 64'(w_ma[i]) * 64'(r_ut);
            w_r[i]    = 64'({r_ph[i][13:0], 16'b0}) + r_pq[i];
            w_q[i]    = (r_ph[i] >> 14) + (w_r[i] >> 30) + 64'(w_r[i][29]);
            if (w_q[i] > 64'(S48_MAX)) begin
                w_q[i] = 64'(S48_MAX) + 64'(r_mneg[i]);
            end
            w_hres[i] = r_mneg[i] ? -$signed(w_q[i][47:0]) : $signed(w_q[i][47:0]);
            // jitter removal
            w_au[i]  = r_acc[i][47] ? 48'(-r_acc[i]) : 48'(r_acc[i]);
            w_jm[i]  = (49'(w_au[i]) + 49'd128) >> 8;
            w_jit[i] = r_acc[i][47] ? -$signed(64'(w_jm[i])) : $signed(64'(w_jm[i]));
            w_js[i]  = sat48(64'(r_p[i]) - w_jit[i]);
            // convergence and update
            w_df[i]  = 64'(r_tg[i]) - 64'(r_j[i]);
            w_ok[i]  = (w_df[i] == 64'sd0) || (w_df[i] == 64'sd1) || (w_df[i] == -64'sd1);
            w_upd[i] = sat48(64'(r_tg[i]) + 64'(r_p[i]) - 64'(r_j[i]));
            // detector scaling
            w_pm[i]   = 49'(r_j[i]) - 49'(ONE_Q24);
            w_pmul[i] = w_pm[i] * $signed({1'b0, w_sum[i]});
            w_sc[i]   = sat48(64'(w_pmul[i]) + 64'({r_cfg_start[i], 24'b0}));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            if (i_cmd.load_in) begin
                r_p[i] <= w_in[i];
                r_d[i] <= w_in[i];
            end
            if (i_cmd.div_init) begin
                r_dn[i]   <= w_n[i];
                r_dr[i]   <= '0;
                r_dneg[i] <= w_x[i][48];
            end
            if (i_cmd.div_step) begin
                r_dn[i] <= {r_dn[i][48:0], w_ge[i]};
                r_dr[i] <= w_rn[i][7:0];
            end
            if (i_cmd.div_fin) begin
                r_tg[i] <= w_tgn[i];
                r_p[i]  <= w_tgn[i];
            end
            if (i_cmd.t_load) begin
                r_acc[i] <= '0;
            end
            if (i_cmd.h_add) begin
                r_us[i]   <= w_hu[i];
                r_mneg[i] <= w_hs[i][47] ^ r_tneg;
            end
            if (i_cmd.h_mulh) begin
                r_ph[i] <= w_prod[i];
            end
            if (i_cmd.h_mull) begin
                r_pq[i] <= w_prod[i];
            end
            if (i_cmd.h_comb) begin
                r_acc[i] <= w_hres[i];
            end
            if (i_cmd.jit) begin
                r_j[i] <= w_js[i];
            end
            if (i_cmd.scale) begin
                r_p[i] <= r_j[i];
                r_d[i] <= w_sc[i];
            end
            if (i_cmd.update) begin
                r_p[i] <= w_upd[i];
            end
        end
        if (i_cmd.wr_scoef && w_cok) begin
            r_coef[0][w_wa32[CW-1:0]] <= i_item.entry_value;
        end
        if (i_cmd.wr_lcoef && w_cok) begin
            r_coef[1][w_wa32[CW-1:0]] <= i_item.entry_value;
        end
        if (i_cmd.t_load) begin
            r_ut   <= w_rdata[31] ? 32'(-w_rdata) : w_rdata;
            r_tneg <= w_rdata[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_status <= 1'b0;
        end else begin
            if (i_cmd.t_load) begin
                r_k <= '0;
            end else if (i_cmd.h_comb) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_val;
            end
        end
    end

    assign o_sts.h_none = (w_neff == '0);
    assign o_sts.h_last = ((r_k + KW'(1)) == w_neff);
    assign o_sts.conv   = w_ok[0] && w_ok[1];

    assign o_result.parent_sample   = r_p[0];
    assign o_result.parent_line     = r_p[1];
    assign o_result.detector_sample = r_d[0];
    assign o_result.detector_line   = r_d[1];
    assign o_result.status          = r_status;

endmodule
`default_nettype wire

// ===== rtl/core/rsj_chk.sv =====
`default_nettype none
module rsj_chk import rsj_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire t_item   i_item,
    input wire logic    o_valid,
    input wire t_result o_result
);

    logic w_conv;
    assign w_conv = start && !busy &&
                    ((i_item.mode == MODE_P2D) || (i_item.mode == MODE_D2P));

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe outside a transaction");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy) else $error("result strobe not single");

    a_conv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv |=> busy) else $error("conversion did not start");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !w_conv) |=> !busy) else $error("load left block busy");

    a_p2d_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_conv && (i_item.mode == MODE_P2D)) ##5 o_valid |-> !o_result.status)
        else $error("parent to detector reported failure");

endmodule

bind rolling_shutter_jitter_map_unit rsj_chk u_rsj_chk (.*);
`default_nettype wire
